[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define AST_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define AST_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

[rtl/apfr_pkg.sv]
// Constants and codes for the addressed packet receive framer.
// No dependencies; used by the top level and its checker.
package apfr_pkg;

    localparam int BUF_SIZE = 256;
    localparam int CNT_W    = $clog2(BUF_SIZE + 1);

    localparam logic [7:0] PREAMBLE   = 8'hAA;
    localparam logic [7:0] BCAST_ADDR = 8'd254;
    localparam int         HDR_BYTES  = 8;
    localparam int         ADDR_POS   = 1;
    localparam int         LEN_HI_POS = 4;
    localparam int         LEN_LO_POS = 5;

    // event ops
    localparam logic [1:0] OP_BYTE     = 2'd0;
    localparam logic [1:0] OP_LINE_ERR = 2'd1;
    localparam logic [1:0] OP_RELEASE  = 2'd2;

    // frame events
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_START    = 3'd1;
    localparam logic [2:0] EV_ADDR_REJ = 3'd2;
    localparam logic [2:0] EV_TOO_LONG = 3'd3;
    localparam logic [2:0] EV_COMPLETE = 3'd4;
    localparam logic [2:0] EV_LINE_ERR = 3'd5;
    localparam logic [2:0] EV_RELEASED = 3'd6;

endpackage

[rtl/addressed_packet_receive_framer_unit.sv]
// Addressed packet receive framer: one UART event in, one framing result out.
// Depends on apfr_pkg.
//
// One request per clock is taken when the result side keeps up. Each request
// passes an input register, then the framing logic, which updates the framer
// state and fills the result register that drives the outputs. The input
// register stalls while the result register holds an unread result: a new
// request is taken only while the input register is empty or can move on.
// Packet length limit is BUF_SIZE bytes; byte and total counters are sized
// from it.
module addressed_packet_receive_framer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       store_valid,
    output logic [7:0] store_index,
    output logic [7:0] store_byte,
    output logic [2:0] frame_event,
    output logic       receiving,
    output logic       packet_ready,
    output logic [8:0] packet_total,
    output logic [15:0] line_error_count
);
    import apfr_pkg::*;

    logic [7:0]       unit_address_reg;
    logic             s1_valid_reg;
    logic [1:0]       s1_op_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_advance;

    logic             collecting_reg, collecting_next;
    logic             ready_hold_reg, ready_hold_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [CNT_W-1:0] expected_total_reg, expected_total_next;
    logic [7:0]       len_hi_reg, len_hi_next;
    logic [15:0]      err_tally_reg, err_tally_next;

    logic             out_valid_reg;
    logic             store_valid_reg, store_valid_next;
    logic [7:0]       store_index_reg, store_index_next;
    logic [7:0]       store_byte_reg, store_byte_next;
    logic [2:0]       frame_event_reg, frame_event_next;

    logic [16:0]      total;
    logic [CNT_W-1:0] bc_inc;
    logic [CNT_W+7:0] bc_ext;
    logic [CNT_W+8:0] exp_ext;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    assign total  = 17'(HDR_BYTES) + {1'b0, len_hi_reg, s1_byte_reg};
    assign bc_inc = byte_count_reg + CNT_W'(1);
    assign bc_ext = {8'd0, byte_count_reg};

    always_comb
    begin
        collecting_next     = collecting_reg;
        ready_hold_next     = ready_hold_reg;
        byte_count_next     = byte_count_reg;
        expected_total_next = expected_total_reg;
        len_hi_next         = len_hi_reg;
        err_tally_next      = err_tally_reg;
        store_valid_next    = 1'b0;
        store_index_next    = 8'd0;
        store_byte_next     = 8'd0;
        frame_event_next    = EV_NONE;

        case (s1_op_reg)
            OP_LINE_ERR:
            begin
                collecting_next  = 1'b0;
                ready_hold_next  = 1'b0;
                byte_count_next  = '0;
                err_tally_next   = err_tally_reg + 16'd1;
                frame_event_next = EV_LINE_ERR;
            end
            OP_RELEASE:
            begin
                collecting_next  = 1'b0;
                ready_hold_next  = 1'b0;
                byte_count_next  = '0;
                frame_event_next = EV_RELEASED;
            end
            OP_BYTE:
            begin
                if (!ready_hold_reg)
                begin
                    if (!collecting_reg)
                    begin
                        if (s1_byte_reg == PREAMBLE)
                        begin
                            store_valid_next    = 1'b1;
                            store_byte_next     = s1_byte_reg;
                            collecting_next     = 1'b1;
                            expected_total_next = CNT_W'(HDR_BYTES);
                            byte_count_next     = CNT_W'(1);
                            frame_event_next    = EV_START;
                        end
                    end
                    else if (byte_count_reg == CNT_W'(ADDR_POS))
                    begin
                        store_valid_next = 1'b1;
                        store_index_next = 8'(ADDR_POS);
                        store_byte_next  = s1_byte_reg;
                        if (s1_byte_reg == unit_address_reg || s1_byte_reg == BCAST_ADDR)
                        begin
                            byte_count_next = bc_inc;
                        end
                        else
                        begin
                            collecting_next  = 1'b0;
                            byte_count_next  = '0;
                            frame_event_next = EV_ADDR_REJ;
                        end
                    end
                    else
                    begin
                        store_valid_next = 1'b1;
                        store_index_next = bc_ext[7:0];
                        store_byte_next  = s1_byte_reg;
                        if (byte_count_reg == CNT_W'(LEN_HI_POS))
                        begin
                            len_hi_next = s1_byte_reg;
                        end
                        if (byte_count_reg == CNT_W'(LEN_LO_POS) && total > 17'(BUF_SIZE))
                        begin
                            collecting_next     = 1'b0;
                            byte_count_next     = '0;
                            expected_total_next = '0;
                            frame_event_next    = EV_TOO_LONG;
                        end
                        else
                        begin
                            if (byte_count_reg == CNT_W'(LEN_LO_POS))
                            begin
                                expected_total_next = total[CNT_W-1:0];
                            end
                            byte_count_next = bc_inc;
                            if (bc_inc >= expected_total_next)
                            begin
                                ready_hold_next  = 1'b1;
                                frame_event_next = EV_COMPLETE;
                            end
                        end
                    end
                end
            end
            default:
            begin
                frame_event_next = EV_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_address_reg   <= 8'd0;
            s1_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            collecting_reg     <= 1'b0;
            ready_hold_reg     <= 1'b0;
            byte_count_reg     <= '0;
            expected_total_reg <= '0;
            len_hi_reg         <= 8'd0;
            err_tally_reg      <= 16'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unit_address_reg <= cfg_wdata;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg      <= 1'b1;
                collecting_reg     <= collecting_next;
                ready_hold_reg     <= ready_hold_next;
                byte_count_reg     <= byte_count_next;
                expected_total_reg <= expected_total_next;
                len_hi_reg         <= len_hi_next;
                err_tally_reg      <= err_tally_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_op_reg   <= op;
            s1_byte_reg <= rx_byte;
        end
        if (s1_advance)
        begin
            store_valid_reg <= store_valid_next;
            store_index_reg <= store_index_next;
            store_byte_reg  <= store_byte_next;
            frame_event_reg <= frame_event_next;
        end
    end

    // state registers already hold the post-step values
    assign exp_ext = {9'd0, expected_total_reg};

    assign out_valid        = out_valid_reg;
    assign store_valid      = store_valid_reg;
    assign store_index      = store_index_reg;
    assign store_byte       = store_byte_reg;
    assign frame_event      = frame_event_reg;
    assign receiving        = collecting_reg;
    assign packet_ready     = ready_hold_reg;
    assign packet_total     = exp_ext[8:0];
    assign line_error_count = err_tally_reg;

endmodule

[rtl/apfr_checker.sv]
// Port-level checker for the framer, bound to the top level.
// Depends on apfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module apfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_we,
    input logic [7:0] cfg_wdata,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] op,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic       store_valid,
    input logic [7:0] store_index,
    input logic [7:0] store_byte,
    input logic [2:0] frame_event,
    input logic       receiving,
    input logic       packet_ready,
    input logic [8:0] packet_total,
    input logic [15:0] line_error_count
);
    import apfr_pkg::*;

    // a result that has no buffer write carries zero index and byte
    `AST_IMPL(a_idle_write_zero, clk, rst_n, out_valid && !store_valid, store_index == 8'd0 && store_byte == 8'd0)
    // a start writes the preamble at position zero and opens a packet
    `AST_IMPL(a_start, clk, rst_n, out_valid && frame_event == EV_START, store_valid && store_index == 8'd0 && store_byte == PREAMBLE && receiving)
    // completion raises the hold flag
    `AST_IMPL(a_complete, clk, rst_n, out_valid && frame_event == EV_COMPLETE, packet_ready && store_valid)
    // line error and release both drop the framer to idle
    `AST_IMPL(a_clear, clk, rst_n, out_valid && (frame_event == EV_LINE_ERR || frame_event == EV_RELEASED), !receiving && !packet_ready && !store_valid)
    // a result not taken stays offered
    `AST_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

bind addressed_packet_receive_framer_unit apfr_checker u_apfr_checker (.*);
